// ===== rtl/core/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define CHK_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define CHK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/sadc_pkg.sv =====
`timescale 1ns / 1ps

package sadc_pkg;

    localparam int CFG_INDEX_W = 4;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_EIGHT_INPUT  = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_COMMON_LEVEL = 4'd1;

    // item kinds
    localparam logic CMD_TRANSFER  = 1'b0;
    localparam logic CMD_SET_LEVEL = 1'b1;

    // control byte bit positions
    localparam int BIT_PD1   = 1;
    localparam int BIT_SGL   = 2;
    localparam int BIT_UNI   = 3;
    localparam int BIT_SEL0  = 4;
    localparam int BIT_SEL1  = 5;
    localparam int BIT_SEL2  = 6;
    localparam int BIT_START = 7;

    localparam logic [7:0] CH0_RESET_LEVEL = 8'hf0;

    // read phases
    localparam logic [1:0] PHASE_IDLE = 2'd0;
    localparam logic [1:0] PHASE_HIGH = 2'd1;
    localparam logic [1:0] PHASE_LOW  = 2'd2;
    localparam logic [1:0] PHASE_DONE = 2'd3;

    typedef struct packed {
        logic       command;
        logic [7:0] tx_byte;
        logic [2:0] channel;
        logic [7:0] level;
    } sadc_req_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       irq;
    } sadc_rsp_t;

endpackage

// ===== rtl/core/spi_adc_control_byte_converter.sv =====
`timescale 1ns / 1ps

// Serial ADC control-byte converter behind an SPI byte link.
//
// Channels:
//   req : valid/ready beat, either an SPI byte transfer (command = transfer)
//         or a level update for one of eight analog channels.
//   rsp : valid/ready beat, one per req beat, in order: the byte shifted out
//         plus the sticky conversion interrupt after that beat.
//   cfg : valid/ready write beat (index, data); always ready. Index 0 is
//         eight-input mode, index 1 the common level; other indexes are dropped.
// Path: the req accepting edge loads the input register; the beat then moves on
//   to the result register with the conversion and phase state when it advances.
// Throughput: one beat per cycle while rsp is taken; every beat finishes in the
//   single compute pass, so back-to-back beats never wait on state.
// Stall: when rsp is held, the result register keeps its beat and the input
//   register can still take one more; req_ready drops once both are full.
// Reset: levels go to channel 0 = 0xF0, others 0; powered down, phase 0,
//   interrupt clear, eight-input mode off, common level 0; both stages empty.
module spi_adc_control_byte_converter (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_ready,
    input  sadc_pkg::sadc_req_t              req,
    output logic                             rsp_valid,
    input  logic                             rsp_ready,
    output sadc_pkg::sadc_rsp_t              rsp,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sadc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]                       cfg_data
);

    // input stage
    logic                s1_valid_reg;
    sadc_pkg::sadc_req_t s1_data_reg;
    logic                s2_advance;

    // configuration
    logic       eight_input_reg;
    logic [7:0] common_level_reg;

    // levels kept as channel pairs: row r holds {ch 2r+1, ch 2r}
    logic [15:0] level_pair_reg [4];

    // conversion state
    logic       active_reg, active_next;
    logic [1:0] phase_reg, phase_next;
    logic [7:0] result_reg, result_next;
    logic       irq_reg, irq_next;

    // output stage
    logic                rsp_valid_reg;
    sadc_pkg::sadc_rsp_t rsp_data_reg, rsp_data_next;

    // compute signals
    logic [7:0]  tx;
    logic        start;
    logic [2:0]  sel_ch;
    logic [15:0] pair_row;
    logic [7:0]  own_level;
    logic [7:0]  pair_level;
    logic [7:0]  diff;
    logic [1:0]  phase_eff;
    logic [7:0]  rx;

    assign cfg_ready  = 1'b1;
    assign s2_advance = s1_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready  = !s1_valid_reg || s2_advance;
    assign rsp_valid  = rsp_valid_reg;
    assign rsp        = rsp_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eight_input_reg  <= 1'b0;
            common_level_reg <= 8'd0;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == sadc_pkg::CFG_EIGHT_INPUT)
                eight_input_reg <= cfg_data[0];
            else if (cfg_index == sadc_pkg::CFG_COMMON_LEVEL)
                common_level_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (req_ready)
            s1_valid_reg <= req_valid;
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
            s1_data_reg <= req;
    end

    // ---- single-pass conversion logic ----
    assign tx    = s1_data_reg.tx_byte;
    assign start = tx[sadc_pkg::BIT_START];

    // SEL bits decode; four-input mode drops SEL0
    always_comb
    begin
        if (eight_input_reg)
            sel_ch = {tx[sadc_pkg::BIT_SEL1], tx[sadc_pkg::BIT_SEL0], tx[sadc_pkg::BIT_SEL2]};
        else
            sel_ch = {1'b0, tx[sadc_pkg::BIT_SEL1], tx[sadc_pkg::BIT_SEL2]};
    end

    assign pair_row   = level_pair_reg[sel_ch[2:1]];
    assign own_level  = sel_ch[0] ? pair_row[15:8] : pair_row[7:0];
    assign pair_level = sel_ch[0] ? pair_row[7:0]  : pair_row[15:8];
    assign diff = own_level - (tx[sadc_pkg::BIT_SGL] ? common_level_reg : pair_level);

    always_comb
    begin
        active_next = active_reg;
        result_next = result_reg;
        irq_next    = irq_reg;
        phase_eff   = phase_reg;
        phase_next  = phase_reg;
        rx          = 8'd0;
        if (s1_data_reg.command == sadc_pkg::CMD_TRANSFER)
        begin
            if (start)
            begin
                phase_eff   = sadc_pkg::PHASE_IDLE;
                active_next = tx[sadc_pkg::BIT_PD1];
                if (tx[sadc_pkg::BIT_PD1])
                begin
                    // bipolar mode flips the MSB
                    result_next = diff ^ {!tx[sadc_pkg::BIT_UNI], 7'd0};
                    irq_next    = 1'b1;
                end
            end
            phase_next = phase_eff;
            if (active_next)
            begin
                case (phase_eff)
                    sadc_pkg::PHASE_HIGH: rx = {2'b00, result_next[7:2]};
                    sadc_pkg::PHASE_LOW:  rx = {result_next[1:0], 6'd0};
                    default:              rx = 8'd0;
                endcase
                if (phase_eff != sadc_pkg::PHASE_DONE)
                    phase_next = phase_eff + 2'd1;
            end
        end
        rsp_data_next.rx_byte = rx;
        rsp_data_next.irq     = irq_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            phase_reg  <= sadc_pkg::PHASE_IDLE;
            result_reg <= 8'd0;
            irq_reg    <= 1'b0;
            level_pair_reg[0] <= {8'd0, sadc_pkg::CH0_RESET_LEVEL};
            for (int r = 1; r < 4; r++)
                level_pair_reg[r] <= 16'd0;
        end
        else if (s2_advance)
        begin
            active_reg <= active_next;
            phase_reg  <= phase_next;
            result_reg <= result_next;
            irq_reg    <= irq_next;
            if (s1_data_reg.command == sadc_pkg::CMD_SET_LEVEL)
            begin
                if (s1_data_reg.channel[0])
                    level_pair_reg[s1_data_reg.channel[2:1]][15:8] <= s1_data_reg.level;
                else
                    level_pair_reg[s1_data_reg.channel[2:1]][7:0] <= s1_data_reg.level;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (s2_advance)
            rsp_valid_reg <= 1'b1;
        else if (rsp_ready)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s2_advance)
            rsp_data_reg <= rsp_data_next;
    end

endmodule

// ===== rtl/core/sadc_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sadc_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input sadc_pkg::sadc_rsp_t rsp
);

    // beats in flight and interrupt already delivered
    logic [1:0] pending_reg;
    logic       irq_seen_reg;
    logic       req_beat;
    logic       rsp_beat;

    assign req_beat = req_valid && req_ready;
    assign rsp_beat = rsp_valid && rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg  <= 2'd0;
            irq_seen_reg <= 1'b0;
        end
        else
        begin
            pending_reg <= pending_reg + {1'b0, req_beat} - {1'b0, rsp_beat};
            if (rsp_beat && rsp.irq)
                irq_seen_reg <= 1'b1;
        end
    end

    `CHK_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "rsp dropped while stalled")
    `CHK_NOW(a_no_phantom, rsp_valid, pending_reg != 2'd0, "rsp beat without a req beat")
    `CHK_NOW(a_depth, 1'b1, pending_reg != 2'd3, "more than two beats in flight")
    `CHK_NOW(a_irq_sticky, rsp_valid && irq_seen_reg, rsp.irq, "interrupt cleared after being raised")
    `CHK_NOW(a_rx_shape, rsp_valid, rsp.rx_byte[7:6] == 2'b00 || rsp.rx_byte[5:0] == 6'd0, "rx byte shape")

endmodule

bind spi_adc_control_byte_converter sadc_checker u_sadc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);
